@@ sv/bdcs_pkg.sv @@
`default_nettype none

package bdcs_pkg;

  localparam int NUM_BUTTONS   = 4;
  localparam int HOUR_W        = 4;
  localparam int MINUTE_W      = 6;
  localparam int COUNT_W       = 8;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 32;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [PADDR_W-1:0] ADDR_DEBOUNCE_RELOAD = 3'd0;

  localparam int BTN_HOUR   = 0;
  localparam int BTN_MINUTE = 1;
  localparam int BTN_ALARM  = 2;
  localparam int BTN_MODE   = 3;

  localparam logic [COUNT_W-1:0]  RELOAD_RESET = 8'd5;
  localparam logic [HOUR_W-1:0]   HOUR_RESET   = 4'd12;
  localparam logic [HOUR_W-1:0]   HOUR_ELEVEN  = 4'd11;
  localparam logic [HOUR_W-1:0]   HOUR_TWELVE  = 4'd12;
  localparam logic [HOUR_W-1:0]   HOUR_ONE     = 4'd1;
  localparam logic [MINUTE_W-1:0] MINUTE_LAST  = 6'd59;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic                pm;
  } time_t;

  function automatic time_t advance_hour(time_t t);
    time_t r;
    r = t;
    if (t.hour == HOUR_ELEVEN) begin
      r.hour = HOUR_TWELVE;
      r.pm   = ~t.pm;
    end else if (t.hour == HOUR_TWELVE) begin
      r.hour = HOUR_ONE;
    end else begin
      r.hour = t.hour + HOUR_W'(1);
    end
    return r;
  endfunction

  function automatic time_t advance_minute(time_t t);
    time_t r;
    r = t;
    if (t.minute == MINUTE_LAST) begin
      r        = advance_hour(t);
      r.minute = '0;
    end else begin
      r.minute = t.minute + MINUTE_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/bdcs_debounce.sv @@
`default_nettype none

module bdcs_debounce (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic [bdcs_pkg::NUM_BUTTONS-1:0] buttons,
  input  wire logic [bdcs_pkg::COUNT_W-1:0]     reload,
  output logic      [bdcs_pkg::NUM_BUTTONS-1:0] fire
);
  import bdcs_pkg::*;

  logic [COUNT_W-1:0] count      [NUM_BUTTONS];
  logic [COUNT_W-1:0] count_next [NUM_BUTTONS];
  logic [COUNT_W-1:0] loaded     [NUM_BUTTONS];

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      loaded[i] = buttons[i] ? reload : count[i];
      if (loaded[i] != '0) begin
        count_next[i] = loaded[i] - COUNT_W'(1);
      end else begin
        count_next[i] = '0;
      end
      fire[i] = (loaded[i] == COUNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        count[i] <= '0;
      end
    end else if (en) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        count[i] <= count_next[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/button_debounce_clock_setter.sv @@
// Debounces four push buttons and uses the presses to set a 12-hour clock
// and an alarm time. Each request on the slave stream is one 10 ms tick
// carrying the raw button levels; every tick gives exactly one result with
// the clock and alarm state after that tick plus the press, redraw and
// clear-seconds pulses. One tick is taken per clock cycle unless the master
// stream holds the flow; each tick sits in the input register, and its result
// is presented on the master stream when the result register, which also
// holds the updated state, is loaded from it. The debounce
// reload value is set through the APB port at address 0 and should only be
// changed while no ticks are in flight.
`default_nettype none

module button_debounce_clock_setter (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // s_tdata: buttons[3:0], zero padding above
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [bdcs_pkg::IN_TDATA_W-1:0]  s_tdata,
  // m_tdata: clock_hour[3:0], clock_minute[9:4], clock_pm[10],
  // alarm_hour[14:11], alarm_minute[20:15], alarm_pm[21],
  // alarm_enabled[22], edit_alarm_mode[23], press_seen[24], redraw[25],
  // clear_seconds[26], zero padding above
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [bdcs_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bdcs_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [bdcs_pkg::PDATA_W-1:0]     pwdata,
  output logic      [bdcs_pkg::PDATA_W-1:0]     prdata,
  output logic                                  pready
);
  import bdcs_pkg::*;

  logic                   reload_hit;
  logic [COUNT_W-1:0]     debounce_reload;

  logic                   in_valid;
  logic [NUM_BUTTONS-1:0] in_buttons;
  logic                   out_ready;
  logic                   advance;
  logic [NUM_BUTTONS-1:0] fire;

  time_t                  clock_time;
  time_t                  alarm_time;
  logic                   alarm_on;
  logic                   edit_mode;

  time_t                  target;
  time_t                  after_hour;
  time_t                  target_next;
  time_t                  clock_time_next;
  time_t                  alarm_time_next;
  logic                   alarm_on_next;
  logic                   edit_mode_next;
  logic                   press_seen_next;
  logic                   redraw_next;
  logic                   clear_seconds_next;

  logic                   press_seen;
  logic                   redraw;
  logic                   clear_seconds;

  // configuration
  assign pready     = 1'b1;
  assign reload_hit = (paddr[PADDR_W-1:2] == ADDR_DEBOUNCE_RELOAD[PADDR_W-1:2]);
  assign prdata     = reload_hit ? PDATA_W'(debounce_reload) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_reload <= RELOAD_RESET;
    end else if (psel && penable && pwrite && pready && reload_hit) begin
      debounce_reload <= pwdata[COUNT_W-1:0];
    end
  end

  // flow control
  assign out_ready = !m_tvalid || m_tready;
  assign advance   = in_valid && out_ready;
  assign s_tready  = !in_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_buttons <= s_tdata[NUM_BUTTONS-1:0];
    end
  end

  bdcs_debounce u_debounce (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .buttons (in_buttons),
    .reload  (debounce_reload),
    .fire    (fire)
  );

  // presses on the hour and minute buttons act before the mode toggle
  always_comb begin
    target      = edit_mode ? alarm_time : clock_time;
    after_hour  = fire[BTN_HOUR] ? advance_hour(target) : target;
    target_next = fire[BTN_MINUTE] ? advance_minute(after_hour) : after_hour;

    clock_time_next = edit_mode ? clock_time : target_next;
    alarm_time_next = edit_mode ? target_next : alarm_time;
    alarm_on_next   = alarm_on ^ fire[BTN_ALARM];
    edit_mode_next  = edit_mode ^ fire[BTN_MODE];

    press_seen_next    = |fire;
    redraw_next        = fire[BTN_MODE];
    clear_seconds_next = (!edit_mode &&
                          (fire[BTN_HOUR] || fire[BTN_MINUTE] || fire[BTN_ALARM])) ||
                         (fire[BTN_MODE] && edit_mode);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      clock_time <= '{hour: HOUR_RESET, minute: '0, pm: 1'b0};
      alarm_time <= '{hour: HOUR_RESET, minute: '0, pm: 1'b0};
      alarm_on   <= 1'b0;
      edit_mode  <= 1'b0;
    end else begin
      if (out_ready) begin
        m_tvalid <= in_valid;
      end
      if (advance) begin
        clock_time <= clock_time_next;
        alarm_time <= alarm_time_next;
        alarm_on   <= alarm_on_next;
        edit_mode  <= edit_mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      press_seen    <= press_seen_next;
      redraw        <= redraw_next;
      clear_seconds <= clear_seconds_next;
    end
  end

  assign m_tdata = {5'b0, clear_seconds, redraw, press_seen, edit_mode, alarm_on,
                    alarm_time.pm, alarm_time.minute, alarm_time.hour,
                    clock_time.pm, clock_time.minute, clock_time.hour};

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bdcs_pkg::*;

  typedef struct packed {
    logic [4:0]          pad;
    logic                clear_seconds;
    logic                redraw;
    logic                press_seen;
    logic                edit_alarm_mode;
    logic                alarm_enabled;
    logic                alarm_pm;
    logic [MINUTE_W-1:0] alarm_minute;
    logic [HOUR_W-1:0]   alarm_hour;
    logic                clock_pm;
    logic [MINUTE_W-1:0] clock_minute;
    logic [HOUR_W-1:0]   clock_hour;
  } display_t;

  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic                pm;
  } dial_t;

  typedef struct packed {
    logic                   fixed;
    logic [NUM_BUTTONS-1:0] lv;
    display_t               want;
  } row_t;

  typedef enum {READY_ALWAYS, READY_PATTERN, READY_RANDOM} ready_style_t;

  localparam display_t AT_RESET = '{clock_hour: 4'd12, alarm_hour: 4'd12, default: '0};
  localparam display_t AFTER_ALL = '{clock_hour: 4'd1, clock_minute: 6'd1, alarm_hour: 4'd12,
                                     alarm_enabled: 1'b1, edit_alarm_mode: 1'b1,
                                     press_seen: 1'b1, redraw: 1'b1, clear_seconds: 1'b1,
                                     default: '0};

  // reload stays at its reset value of five throughout
  localparam row_t DIRECTED_ROWS [24] = '{
    '{1'b1, 4'b0000, AT_RESET},
    '{1'b1, 4'b1111, AT_RESET},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b1, 4'b0000, AFTER_ALL},
    '{1'b0, 4'b0001, '0},
    '{1'b0, 4'b0001, '0},
    '{1'b0, 4'b0001, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b1010, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0100, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0000, '0},
    '{1'b0, 4'b0000, '0}
  };

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [PDATA_W-1:0]      pwdata = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  // predictor state
  logic [COUNT_W-1:0] countdown [NUM_BUTTONS] = '{default: '0};
  logic [COUNT_W-1:0] reload_val = 8'd5;
  dial_t              clock_dial = '{4'd12, 6'd0, 1'b0};
  dial_t              alarm_dial = '{4'd12, 6'd0, 1'b0};
  logic               armed = 1'b0;
  logic               editing = 1'b0;

  display_t display_q [$];
  int       fault_count = 0;
  int       burst_left = 0;
  int       hold_left [NUM_BUTTONS];
  int       idle_left [NUM_BUTTONS];
  int       stall_left = 0;
  ready_style_t ready_style = READY_ALWAYS;
  logic [31:0]  ready_mask = '1;

  button_debounce_clock_setter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic dial_t bump_hour(input dial_t d);
    dial_t r;
    r = d;
    if (d.hour == 4'd11) begin
      r.hour = 4'd12;
      r.pm   = ~d.pm;
    end else if (d.hour == 4'd12) begin
      r.hour = 4'd1;
    end else begin
      r.hour = d.hour + 4'd1;
    end
    return r;
  endfunction

  function automatic dial_t bump_minute(input dial_t d);
    dial_t r;
    if (d.minute == 6'd59) begin
      r = bump_hour(d);
      r.minute = 6'd0;
    end else begin
      r = d;
      r.minute = d.minute + 6'd1;
    end
    return r;
  endfunction

  function automatic display_t predict_tick(input logic [NUM_BUTTONS-1:0] lv);
    display_t d;
    d = '0;
    for (int b = 0; b < NUM_BUTTONS; b++)
      if (lv[b]) countdown[b] = reload_val;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (countdown[b] != 0) begin
        countdown[b] = countdown[b] - 1'b1;
        if (countdown[b] == 0) begin
          d.press_seen = 1'b1;
          if (b == BTN_ALARM) armed = ~armed;
          if (b == BTN_MODE) begin
            editing  = ~editing;
            d.redraw = 1'b1;
          end
          // target follows the mode as it stands after this press
          if (!editing) d.clear_seconds = 1'b1;
          if (b == BTN_HOUR) begin
            if (editing) alarm_dial = bump_hour(alarm_dial);
            else clock_dial = bump_hour(clock_dial);
          end else if (b == BTN_MINUTE) begin
            if (editing) alarm_dial = bump_minute(alarm_dial);
            else clock_dial = bump_minute(clock_dial);
          end
        end
      end
    end
    d.clock_hour      = clock_dial.hour;
    d.clock_minute    = clock_dial.minute;
    d.clock_pm        = clock_dial.pm;
    d.alarm_hour      = alarm_dial.hour;
    d.alarm_minute    = alarm_dial.minute;
    d.alarm_pm        = alarm_dial.pm;
    d.alarm_enabled   = armed;
    d.edit_alarm_mode = editing;
    return d;
  endfunction

  function automatic void note_mismatch(input string name, input int want, input int got);
    fault_count++;
    $display("%0t: %s expected %0d got %0d", $time, name, want, got);
  endfunction

  task automatic send_tick(input logic [NUM_BUTTONS-1:0] lv, input logic fixed,
                           input display_t want);
    int       gap;
    display_t d;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-NUM_BUTTONS){1'b0}}, lv};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    d = predict_tick(lv);
    display_q.push_back(fixed ? want : d);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    psel   <= 1'b1;
    pwrite <= wr;
    paddr  <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    penable <= 1'b0;
  endtask

  task automatic set_reload(input logic [COUNT_W-1:0] v);
    logic [PDATA_W-1:0] rd;
    s_tvalid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk);
    apb_access(1'b1, ADDR_DEBOUNCE_RELOAD, {{(PDATA_W-COUNT_W){1'b0}}, v}, rd);
    reload_val = v;
    apb_access(1'b0, ADDR_DEBOUNCE_RELOAD, '0, rd);
    psel <= 1'b0;
    if (rd != {{(PDATA_W-COUNT_W){1'b0}}, v}) begin
      fault_count++;
      $display("%0t: debounce_reload readback expected %0d got %0d", $time, v, rd);
    end
  endtask

  // presses with random hold and quiet spells, some ticks replaced by noise
  task automatic run_random(input int n);
    int slack;
    logic [NUM_BUTTONS-1:0] lv;
    slack = reload_val + reload_val / 2 + 2;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      hold_left[b] = 0;
      idle_left[b] = $urandom_range(0, slack);
    end
    repeat (n) begin
      lv = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (hold_left[b] != 0) begin
          lv[b] = 1'b1;
          hold_left[b]--;
        end else if (idle_left[b] != 0) begin
          idle_left[b]--;
        end else begin
          lv[b] = 1'b1;
          hold_left[b] = $urandom_range(0, 3);
          idle_left[b] = $urandom_range(0, slack);
        end
      end
      if ($urandom_range(0, 9) == 0) lv = NUM_BUTTONS'($urandom_range(0, 15));
      send_tick(lv, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left  = $urandom_range(16, 96);
      ready_style = ready_style_t'($urandom_range(0, 2));
      ready_mask  = $urandom;
    end
    stall_left--;
    case (ready_style)
      READY_ALWAYS:  m_tready <= 1'b1;
      READY_PATTERN: m_tready <= ready_mask[stall_left % 32];
      default:       m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    display_t got;
    display_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (display_q.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result, expected none got %h", $time, m_tdata);
      end else begin
        want = display_q.pop_front();
        if (want.clock_hour != got.clock_hour)
          note_mismatch("clock_hour", want.clock_hour, got.clock_hour);
        if (want.clock_minute != got.clock_minute)
          note_mismatch("clock_minute", want.clock_minute, got.clock_minute);
        if (want.clock_pm != got.clock_pm)
          note_mismatch("clock_pm", want.clock_pm, got.clock_pm);
        if (want.alarm_hour != got.alarm_hour)
          note_mismatch("alarm_hour", want.alarm_hour, got.alarm_hour);
        if (want.alarm_minute != got.alarm_minute)
          note_mismatch("alarm_minute", want.alarm_minute, got.alarm_minute);
        if (want.alarm_pm != got.alarm_pm)
          note_mismatch("alarm_pm", want.alarm_pm, got.alarm_pm);
        if (want.alarm_enabled != got.alarm_enabled)
          note_mismatch("alarm_enabled", want.alarm_enabled, got.alarm_enabled);
        if (want.edit_alarm_mode != got.edit_alarm_mode)
          note_mismatch("edit_alarm_mode", want.edit_alarm_mode, got.edit_alarm_mode);
        if (want.press_seen != got.press_seen)
          note_mismatch("press_seen", want.press_seen, got.press_seen);
        if (want.redraw != got.redraw)
          note_mismatch("redraw", want.redraw, got.redraw);
        if (want.clear_seconds != got.clear_seconds)
          note_mismatch("clear_seconds", want.clear_seconds, got.clear_seconds);
        if (want.pad != got.pad)
          note_mismatch("padding", want.pad, got.pad);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int waited;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i])
      send_tick(DIRECTED_ROWS[i].lv, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);

    // reload of one: held buttons fire every tick, sweep minutes and hours in both modes
    set_reload(8'd1);
    for (int m = 0; m < 2; m++) begin
      repeat (62) send_tick(4'b0010, 1'b0, '0);
      repeat (26) send_tick(4'b0001, 1'b0, '0);
      send_tick(4'b1000, 1'b0, '0);
    end
    run_random(60);

    // reload of zero: nothing fires
    set_reload(8'd0);
    run_random(40);

    set_reload(8'd255);
    run_random(260);

    set_reload(8'd2);
    run_random(80);

    set_reload(COUNT_W'($urandom_range(3, 12)));
    run_random(80);

    set_reload(8'd5);
    run_random(60);

    s_tvalid <= 1'b0;
    waited = 0;
    while (display_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (display_q.size() != 0) begin
      fault_count++;
      $display("%0t: %0d results never arrived", $time, display_q.size());
    end
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/bdcs_pkg.sv
sv/bdcs_debounce.sv
sv/button_debounce_clock_setter.sv
tb/sv/testbench.sv
